FILE: hdl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants of the straight-move controller
// Register indexes, fixed field widths, reset values and control structs.
// ----------------------------------------------------------------------------
package tws_pkg;

  // defaults of the top-level parameters
  localparam int COUNT_BITS_DEF      = 16;
  localparam int DISTANCE_BITS_DEF   = 24;
  localparam int DRIVE_FRAC_BITS_DEF = 14;
  localparam int GAIN_FRAC_BITS_DEF  = 8;

  // fixed widths
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int SPEED_BITS     = 10;
  localparam int STEP_BITS      = 8;
  localparam int GAIN_BITS      = 24;
  localparam int TRAVEL_BITS    = 32;
  // 4*target minus the sum of both distances, signed
  localparam int BRAKE_BITS     = TRAVEL_BITS + 4;

  // register reset values
  localparam logic [SPEED_BITS-1:0] GOAL_RESET = SPEED_BITS'(400);
  localparam logic [STEP_BITS-1:0]  STEP_RESET = STEP_BITS'(10);
  localparam logic [SPEED_BITS-1:0] MIN_RESET  = SPEED_BITS'(60);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TARGET_DISTANCE,
    REG_GOAL_SPEED,
    REG_SPEED_STEP,
    REG_MIN_SPEED,
    REG_GAIN_PROP,
    REG_GAIN_INTEG,
    REG_GAIN_DERIV
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL,
    ST_SUM,
    ST_RAMP,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic clear;
    logic err_en;
    logic mul_en;
    logic sum_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic clear;
    logic commit;
  } ramp_ctrl_t;

endpackage

FILE: hdl/tws_lane.sv
// ----------------------------------------------------------------------------
// tws_lane: one wheel's PID lane
// Error, three gain products, rounded correction, saturated drive, distance.
// ----------------------------------------------------------------------------
module tws_lane #(
  parameter int COUNT_BITS      = tws_pkg::COUNT_BITS_DEF,
  parameter int DRIVE_FRAC_BITS = tws_pkg::DRIVE_FRAC_BITS_DEF,
  parameter int GAIN_FRAC_BITS  = tws_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  tws_pkg::lane_ctrl_t                      ctrl,
  input  logic signed [COUNT_BITS-1:0]             count,
  input  logic signed [COUNT_BITS+1:0]             skew,
  input  logic [tws_pkg::SPEED_BITS-1:0]           setpoint,
  input  logic [tws_pkg::SPEED_BITS-1:0]           goal,
  input  logic signed [tws_pkg::GAIN_BITS-1:0]     gain_p,
  input  logic signed [tws_pkg::GAIN_BITS-1:0]     gain_i,
  input  logic signed [tws_pkg::GAIN_BITS-1:0]     gain_d,
  output logic signed [DRIVE_FRAC_BITS+1:0]        drive,
  output logic signed [tws_pkg::TRAVEL_BITS-1:0]   travelled
);
  import tws_pkg::*;

  localparam int MB  = (COUNT_BITS > SPEED_BITS) ? COUNT_BITS : SPEED_BITS;
  localparam int EB  = MB + 3;
  localparam int D2B = EB + 2;
  localparam int PB  = GAIN_BITS + D2B;
  localparam int SB  = PB + 3;
  localparam int DB  = SB + 1;
  localparam int DW  = DRIVE_FRAC_BITS + 2;
  localparam int TB  = TRAVEL_BITS;

  localparam logic signed [SB-1:0] HALF      = SB'(2**GAIN_FRAC_BITS / 2);
  localparam logic signed [DB-1:0] FULL_POS  = DB'(2**DRIVE_FRAC_BITS);
  localparam logic signed [DB-1:0] FULL_NEG  = -FULL_POS;
  localparam logic signed [TB:0]   T_MAX     = {2'b00, {(TB-1){1'b1}}};
  localparam logic signed [TB:0]   T_MIN     = {2'b11, {(TB-1){1'b0}}};

  logic signed [EB-1:0]  err, last, prev_err, err_next;
  logic signed [D2B-1:0] d2;
  logic signed [PB-1:0]  prod_p, prod_i, prod_d;
  logic signed [SB-1:0]  corr, corr_sh;
  logic signed [DB-1:0]  drive_wide;
  logic signed [DW-1:0]  drive_next;
  logic signed [TB:0]    trav_sum;
  logic signed [TB-1:0]  trav_next;

  assign err_next = EB'(count) - EB'(signed'({1'b0, setpoint})) + EB'(skew);

  // rounding to nearest, ties up: add half then floor
  assign corr    = SB'(prod_p) + SB'(prod_i) + SB'(prod_d) + HALF;
  assign corr_sh = corr >>> GAIN_FRAC_BITS;
  assign drive_wide = DB'(drive) - DB'(corr_sh);

  always_comb begin
    if (drive_wide > FULL_POS) begin
      drive_next = DW'(FULL_POS);
    end else if (drive_wide < FULL_NEG) begin
      drive_next = DW'(FULL_NEG);
    end else begin
      drive_next = DW'(drive_wide);
    end
  end

  assign trav_sum = (TB+1)'(travelled) + (TB+1)'(count);

  always_comb begin
    if (trav_sum > T_MAX) begin
      trav_next = TB'(T_MAX);
    end else if (trav_sum < T_MIN) begin
      trav_next = TB'(T_MIN);
    end else begin
      trav_next = TB'(trav_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive     <= '0;
      prev_err  <= EB'(signed'({1'b0, GOAL_RESET}));
      travelled <= '0;
    end else if (ctrl.clear) begin
      drive     <= '0;
      prev_err  <= EB'(signed'({1'b0, goal}));
      travelled <= '0;
    end else begin
      if (ctrl.err_en) begin
        prev_err  <= err_next;
        travelled <= trav_next;
      end
      if (ctrl.sum_en) begin
        drive <= drive_next;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.err_en) begin
      err  <= err_next;
      last <= prev_err;
      d2   <= D2B'(err_next) + D2B'(err_next) - D2B'(prev_err);
    end
    if (ctrl.mul_en) begin
      prod_p <= PB'(gain_p) * PB'(err);
      prod_i <= PB'(gain_i) * PB'(last);
      prod_d <= PB'(gain_d) * PB'(d2);
    end
  end

endmodule

FILE: hdl/tws_ramp.sv
// ----------------------------------------------------------------------------
// tws_ramp: merge stage of both lanes
// Reach flags, finish, setpoint ramp, acceleration and braking decisions.
// ----------------------------------------------------------------------------
module tws_ramp #(
  parameter int DISTANCE_BITS = tws_pkg::DISTANCE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  tws_pkg::ramp_ctrl_t                     ctrl,
  input  logic signed [tws_pkg::TRAVEL_BITS-1:0]  trav_left,
  input  logic signed [tws_pkg::TRAVEL_BITS-1:0]  trav_right,
  input  logic [DISTANCE_BITS-1:0]                target,
  input  logic [tws_pkg::SPEED_BITS-1:0]          goal,
  input  logic [tws_pkg::STEP_BITS-1:0]           step,
  input  logic [tws_pkg::SPEED_BITS-1:0]          min_speed,
  output logic [tws_pkg::SPEED_BITS-1:0]          setpoint,
  output logic                                    finished,
  output logic                                    reach_left,
  output logic                                    reach_right
);
  import tws_pkg::*;

  localparam int BB  = BRAKE_BITS;
  localparam int SPW = SPEED_BITS + 2;

  logic                  may_acc, may_acc_next;
  logic signed [BB-1:0]  brake_pt, brake_pt_next;
  logic                  brake_valid, brake_valid_next;
  logic signed [BB-1:0]  tgt_s, tl, tr;
  logic                  half_hit, quad_hit;
  logic signed [SPW-1:0] sp_w, goal_w, step_w, lo_w, sp_next;

  assign tgt_s = BB'(signed'({1'b0, target}));
  assign tl    = BB'(trav_left);
  assign tr    = BB'(trav_right);

  assign reach_left  = tl >= tgt_s;
  assign reach_right = tr >= tgt_s;
  assign half_hit    = ((tl <<< 1) >= tgt_s) || ((tr <<< 1) >= tgt_s);

  assign sp_w   = SPW'(signed'({1'b0, setpoint}));
  assign goal_w = SPW'(signed'({1'b0, goal}));
  assign step_w = SPW'(signed'({1'b0, step}));
  assign lo_w   = SPW'(signed'({1'b0, min_speed}));

  always_comb begin
    sp_next = sp_w;
    if (may_acc) begin
      if (sp_w != goal_w) begin
        sp_next = sp_w + step_w;
        if (sp_next > goal_w) begin
          sp_next = goal_w;
        end
      end
    end else if (sp_w > lo_w) begin
      sp_next = sp_w - step_w;
      if (sp_next < lo_w) begin
        sp_next = lo_w;
      end
    end

    may_acc_next = may_acc;
    if (may_acc && half_hit && (sp_next < goal_w)) begin
      may_acc_next = 1'b0;
    end

    brake_pt_next    = brake_pt;
    brake_valid_next = brake_valid;
    if (sp_next >= goal_w - step_w) begin
      brake_pt_next    = (tgt_s <<< 2) - (tl + tr);
      brake_valid_next = 1'b1;
    end

    quad_hit = ((tl <<< 2) >= brake_pt_next) || ((tr <<< 2) >= brake_pt_next);
    if (brake_valid_next && quad_hit) begin
      may_acc_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      setpoint    <= '0;
      may_acc     <= 1'b1;
      brake_pt    <= '0;
      brake_valid <= 1'b0;
      finished    <= 1'b0;
    end else if (ctrl.commit) begin
      setpoint    <= SPEED_BITS'(sp_next);
      may_acc     <= may_acc_next;
      brake_pt    <= brake_pt_next;
      brake_valid <= brake_valid_next;
      finished    <= reach_left && reach_right;
    end
  end

endmodule

FILE: hdl/two_wheel_straight_move_pid.sv
// ----------------------------------------------------------------------------
// two_wheel_straight_move_pid: straight-move PID controller for two wheels
// Input buffer, sequencer, two wheel lanes, ramp merge stage, output register.
// ----------------------------------------------------------------------------
// Usage:
//  Slave channel s_*: one item per control period. s_tuser = 1 starts a new
//  move (state cleared), 0 is a control tick carrying both encoder counts.
//  Master channel m_*: exactly one result item per input item, in order.
//  Config channel cfg_*: always ready; write only while the block is idle.
//  Timing: an item sits in a one-entry input buffer, then a tick runs
//  dispatch, error, multiply, sum, ramp and push in turn; the next tick
//  starts only after push, due to the sequential dependency of the next
//  error on the ramped setpoint and the lane drive. Start items and ticks
//  after finishing go from dispatch straight to push.
//  Both lanes have their own three multipliers, used in the multiply cycle.
//  The next item is accepted while the current one is at work or its result
//  waits in the output register. A stalled receiver holds the result in
//  the output register; the sequencer waits in push until it is taken.
//  Reset: registers to defaults, move state cleared, no item held.
// ----------------------------------------------------------------------------
module two_wheel_straight_move_pid #(
  parameter int COUNT_BITS      = tws_pkg::COUNT_BITS_DEF,
  parameter int DISTANCE_BITS   = tws_pkg::DISTANCE_BITS_DEF,
  parameter int DRIVE_FRAC_BITS = tws_pkg::DRIVE_FRAC_BITS_DEF,
  parameter int GAIN_FRAC_BITS  = tws_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // [COUNT_BITS-1:0] left_count, [2*COUNT_BITS-1:COUNT_BITS] right_count
  input  logic [((2*COUNT_BITS+7)/8)*8-1:0]         s_tdata,
  // [0] action
  input  logic                                      s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // left_drive, right_drive, move_done, speed_now (10 bits), then zero pad
  output logic [((2*DRIVE_FRAC_BITS+12+tws_pkg::SPEED_BITS)/8)*8-1:0] m_tdata,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [tws_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [tws_pkg::CFG_DATA_BITS-1:0]         cfg_data
);
  import tws_pkg::*;

  localparam int C        = COUNT_BITS;
  localparam int DW       = DRIVE_FRAC_BITS + 2;
  localparam int OUT_RAW  = 2 * DW + 1 + SPEED_BITS;
  localparam int OUT_BITS = ((2 * DRIVE_FRAC_BITS + 12 + SPEED_BITS) / 8) * 8;

  // configuration registers
  logic [DISTANCE_BITS-1:0]     target;
  logic [SPEED_BITS-1:0]        goal;
  logic [STEP_BITS-1:0]         step;
  logic [SPEED_BITS-1:0]        min_speed;
  logic signed [GAIN_BITS-1:0]  gain_p, gain_i, gain_d;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target    <= '0;
      goal      <= GOAL_RESET;
      step      <= STEP_RESET;
      min_speed <= MIN_RESET;
      gain_p    <= '0;
      gain_i    <= '0;
      gain_d    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_DISTANCE: target    <= cfg_data[DISTANCE_BITS-1:0];
        REG_GOAL_SPEED:      goal      <= cfg_data[SPEED_BITS-1:0];
        REG_SPEED_STEP:      step      <= cfg_data[STEP_BITS-1:0];
        REG_MIN_SPEED:       min_speed <= cfg_data[SPEED_BITS-1:0];
        REG_GAIN_PROP:       gain_p    <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_INTEG:      gain_i    <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_DERIV:      gain_d    <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // one-entry input buffer
  logic                 in_full;
  logic                 buf_action;
  logic signed [C-1:0]  buf_left, buf_right;
  logic                 take;

  assign s_tready = !in_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      buf_action <= s_tuser;
      buf_left   <= s_tdata[C-1:0];
      buf_right  <= s_tdata[2*C-1:C];
    end
  end

  // sequencer
  state_t     state, state_next;
  lane_ctrl_t lane_ctrl;
  ramp_ctrl_t ramp_ctrl;
  logic       load_work, diff_en, out_load, out_free;
  logic       finished, reach_left, reach_right;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    lane_ctrl  = '0;
    ramp_ctrl  = '0;
    take       = 1'b0;
    load_work  = 1'b0;
    diff_en    = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_full) begin
          take = 1'b1;
          if (buf_action) begin
            lane_ctrl.clear = 1'b1;
            ramp_ctrl.clear = 1'b1;
            state_next      = ST_PUSH;
          end else if (finished) begin
            state_next = ST_PUSH;
          end else begin
            load_work  = 1'b1;
            state_next = ST_ERR;
          end
        end
      end
      ST_ERR: begin
        lane_ctrl.err_en = 1'b1;
        diff_en          = 1'b1;
        state_next       = ST_MUL;
      end
      ST_MUL: begin
        lane_ctrl.mul_en = 1'b1;
        state_next       = ST_SUM;
      end
      ST_SUM: begin
        lane_ctrl.sum_en = 1'b1;
        state_next       = ST_RAMP;
      end
      ST_RAMP: begin
        ramp_ctrl.commit = 1'b1;
        state_next       = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // working counts and the wheel difference of the last tick
  logic signed [C-1:0] work_left, work_right;
  logic signed [C:0]   diff;
  logic signed [C+1:0] skew_left, skew_right;

  always_ff @(posedge clk) begin
    if (load_work) begin
      work_left  <= buf_left;
      work_right <= buf_right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || lane_ctrl.clear) begin
      diff <= '0;
    end else if (diff_en) begin
      diff <= (C+1)'(work_left) - (C+1)'(work_right);
    end
  end

  assign skew_left  = (C+2)'(diff);
  assign skew_right = -skew_left;

  // lanes
  logic signed [DW-1:0]          drive_left, drive_right;
  logic signed [TRAVEL_BITS-1:0] trav_left, trav_right;
  logic [SPEED_BITS-1:0]         setpoint;

  tws_lane #(
    .COUNT_BITS      (COUNT_BITS),
    .DRIVE_FRAC_BITS (DRIVE_FRAC_BITS),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
  ) u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lane_ctrl),
    .count     (work_left),
    .skew      (skew_left),
    .setpoint  (setpoint),
    .goal      (goal),
    .gain_p    (gain_p),
    .gain_i    (gain_i),
    .gain_d    (gain_d),
    .drive     (drive_left),
    .travelled (trav_left)
  );

  tws_lane #(
    .COUNT_BITS      (COUNT_BITS),
    .DRIVE_FRAC_BITS (DRIVE_FRAC_BITS),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
  ) u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lane_ctrl),
    .count     (work_right),
    .skew      (skew_right),
    .setpoint  (setpoint),
    .goal      (goal),
    .gain_p    (gain_p),
    .gain_i    (gain_i),
    .gain_d    (gain_d),
    .drive     (drive_right),
    .travelled (trav_right)
  );

  tws_ramp #(
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_ramp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ramp_ctrl),
    .trav_left   (trav_left),
    .trav_right  (trav_right),
    .target      (target),
    .goal        (goal),
    .step        (step),
    .min_speed   (min_speed),
    .setpoint    (setpoint),
    .finished    (finished),
    .reach_left  (reach_left),
    .reach_right (reach_right)
  );

  // output register; a finished move or a reached wheel drives zero
  logic [DW-1:0] out_left, out_right;

  assign out_left  = (finished || reach_left)  ? '0 : drive_left;
  assign out_right = (finished || reach_right) ? '0 : drive_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_BITS'({setpoint, finished, out_right, out_left});
    end
  end

  // packed result width check against the port width
  logic [OUT_RAW-1:0] unused_raw;
  assign unused_raw = m_tdata[OUT_RAW-1:0];

endmodule

FILE: hdl/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker: port-level checks of the straight-move controller
// Reset behavior, result hold under stall, drive range and finish rules.
// ----------------------------------------------------------------------------
module tws_checker #(
  parameter int COUNT_BITS      = tws_pkg::COUNT_BITS_DEF,
  parameter int DISTANCE_BITS   = tws_pkg::DISTANCE_BITS_DEF,
  parameter int DRIVE_FRAC_BITS = tws_pkg::DRIVE_FRAC_BITS_DEF,
  parameter int GAIN_FRAC_BITS  = tws_pkg::GAIN_FRAC_BITS_DEF
) (
  input logic                                      clk,
  input logic                                      rst,
  input logic                                      s_tvalid,
  input logic                                      s_tready,
  input logic [((2*COUNT_BITS+7)/8)*8-1:0]         s_tdata,
  input logic                                      s_tuser,
  input logic                                      m_tvalid,
  input logic                                      m_tready,
  input logic [((2*DRIVE_FRAC_BITS+12+tws_pkg::SPEED_BITS)/8)*8-1:0] m_tdata,
  input logic                                      cfg_valid,
  input logic                                      cfg_ready,
  input logic [tws_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input logic [tws_pkg::CFG_DATA_BITS-1:0]         cfg_data
);
  import tws_pkg::*;

  localparam int DW = DRIVE_FRAC_BITS + 2;
  localparam logic signed [DW-1:0] FULL_POS = DW'(2**DRIVE_FRAC_BITS);
  localparam logic signed [DW-1:0] FULL_NEG = -FULL_POS;

  logic signed [DW-1:0] left_drive, right_drive;
  logic                 move_done;
  logic                 unused_in;

  assign left_drive  = m_tdata[DW-1:0];
  assign right_drive = m_tdata[2*DW-1:DW];
  assign move_done   = m_tdata[2*DW];
  assign unused_in   = s_tvalid ^ s_tuser ^ (^s_tdata) ^ cfg_valid ^ cfg_ready
                     ^ (^cfg_index) ^ (^cfg_data) ^ GAIN_FRAC_BITS[0]
                     ^ DISTANCE_BITS[0];

  a_reset_state: assert property (@(posedge clk)
    rst |=> (s_tready && !m_tvalid))
    else $error("buffer or output register not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (left_drive <= FULL_POS && left_drive >= FULL_NEG &&
                  right_drive <= FULL_POS && right_drive >= FULL_NEG))
    else $error("drive outside full scale");

  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && move_done) |-> (left_drive == '0 && right_drive == '0))
    else $error("finished move with nonzero drive");

endmodule

bind two_wheel_straight_move_pid tws_checker #(
  .COUNT_BITS      (COUNT_BITS),
  .DISTANCE_BITS   (DISTANCE_BITS),
  .DRIVE_FRAC_BITS (DRIVE_FRAC_BITS),
  .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
) u_tws_checker (.*);
